// ----- rtl/core/isaac_pkg.sv -----
package isaac_pkg;
  localparam int WORDS = 256;
  localparam logic [31:0] GOLDEN = 32'h9e3779b9;
  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_DRAW = 2'd2;
endpackage

// ----- rtl/core/isaac_random_generator.sv -----
// ISAAC 32-bit generator with a 256-word state memory and a 256-word result
// buffer. A command is taken at a clock edge with start high and busy low, and
// each command answers with exactly one out_valid pulse that the receiver
// cannot stall. A seed write or an unused op code is answered in the next cycle
// and leaves busy low, so such commands can follow back to back. A draw waits
// in S_DRAW for the buffer read and answers with the registered word; busy
// falls with that answer unless the draw uses up the buffer. That draw then
// runs a refill round of 256 steps through S_GRD to S_GB (four state reads,
// one state write and one result write per step) with busy high.
// Initialization mixes eight words at a time: four initial mixes, then per
// group of eight words a mix and a write, with the seed words added first and
// two passes when a seed is used, then a refill round that ends with its answer.
// After reset a clearing pass over all 256 addresses zeroes both memories with busy high.
module isaac_random_generator
  import isaac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_seed_index,
  input  logic [31:0] in_seed_word,
  input  logic        in_use_seed,
  output logic        out_valid,
  output logic [31:0] out_value,
  output logic        out_is_random
);
  localparam int AW = $clog2(WORDS);
  localparam int HALF = WORDS / 2;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DRAW, S_PRE, S_GRD, S_GWR, S_GPA, S_GRA, S_GX, S_GY,
    S_GB, S_DONE
  } state_t;

  state_t state_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] c_r;
  logic [2:0] k_r;
  logic [1:0] mcnt_r;
  logic [2:0] pk_r;
  logic [2:0] mrow_r;
  logic pass_r, seeded_r, ack_draw_r;
  logic [31:0] a_r, b_r, cnt_r, x_r, y_r;
  logic [31:0] v_r [8];
  logic [31:0] mv [8];
  logic [31:0] av, sh, yb, seedw;
  logic [2:0] row1, row2, row3;
  logic valid_nxt;

  logic sm_we, rb_we;
  logic [AW-1:0] sm_wa, sm_ra, rb_wa, rb_ra;
  logic [31:0] sm_wd, rb_wd, sm_rd, rb_rd;

  isaac_ram #(.WIDTH(32), .DEPTH(WORDS)) u_sm (
    .clk(clk), .we(sm_we), .waddr(sm_wa), .wdata(sm_wd), .raddr(sm_ra), .rdata(sm_rd));
  isaac_ram #(.WIDTH(32), .DEPTH(WORDS)) u_rb (
    .clk(clk), .we(rb_we), .waddr(rb_wa), .wdata(rb_wd), .raddr(rb_ra), .rdata(rb_rd));

  // One row of the eight-word mix is applied per cycle.
  always_comb begin
    row1 = mrow_r + 3'd1;
    row2 = mrow_r + 3'd2;
    row3 = mrow_r + 3'd3;
    case (mrow_r)
      3'd0: sh = v_r[1] << 11;
      3'd1: sh = v_r[2] >> 2;
      3'd2: sh = v_r[3] << 8;
      3'd3: sh = v_r[4] >> 16;
      3'd4: sh = v_r[5] << 10;
      3'd5: sh = v_r[6] >> 4;
      3'd6: sh = v_r[7] << 8;
      default: sh = v_r[0] >> 9;
    endcase
    for (int j = 0; j < 8; j++) mv[j] = v_r[j];
    mv[mrow_r] = v_r[mrow_r] ^ sh;
    mv[row3] = v_r[row3] + mv[mrow_r];
    mv[row1] = v_r[row1] + v_r[row2];
  end

  always_comb begin
    case (idx_r[1:0])
      2'd0: av = a_r ^ (a_r << 13);
      2'd1: av = a_r ^ (a_r >> 6);
      2'd2: av = a_r ^ (a_r << 2);
      default: av = a_r ^ (a_r >> 16);
    endcase
  end

  always_comb begin
    sm_we = 1'b0; sm_wa = idx_r; sm_wd = 32'd0; sm_ra = idx_r;
    rb_we = 1'b0; rb_wa = idx_r; rb_wd = 32'd0; rb_ra = c_r;
    case (state_r)
      S_CLR: begin
        sm_we = 1'b1; rb_we = 1'b1;
      end
      S_IDLE: begin
        rb_we = start && !busy && in_op == OP_SEED;
        rb_wa = in_seed_index; rb_wd = in_seed_word;
      end
      S_PRE: begin
        rb_ra = {idx_r[AW-1:3], k_r};
        sm_ra = {idx_r[AW-1:3], k_r};
        if (mcnt_r == 2'd3) begin
          sm_we = 1'b1; sm_wa = {idx_r[AW-1:3], k_r}; sm_wd = v_r[k_r];
        end
      end
      S_GWR: sm_ra = idx_r + AW'(HALF);
      S_GPA: sm_ra = x_r[AW+1:2];
      S_GX: begin
        sm_we = 1'b1; sm_wd = y_r; sm_ra = y_r[AW+9:10];
      end
      S_GB: begin
        rb_we = 1'b1; rb_wd = b_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: valid_nxt = start && !(in_op inside {OP_DRAW, OP_INIT});
      S_DRAW: valid_nxt = ack_draw_r;
      S_DONE: valid_nxt = !ack_draw_r;
      default: ;
    endcase
  end

  assign seedw = pass_r ? sm_rd : rb_rd;
  // The word just written is read back when its own index is addressed.
  assign yb = (y_r[AW+9:10] == idx_r) ? y_r : sm_rd;

  // S_PRE sub phases: mcnt 0 issue reads k=0..7 and accumulate each word as it
  // returns, 1 accumulate the last word, 2 mix, 3 write words out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; idx_r <= '0; out_valid <= 1'b0; busy <= 1'b1;
      out_value <= '0; out_is_random <= 1'b0;
      a_r <= '0; b_r <= '0; cnt_r <= '0; c_r <= '0; k_r <= '0; mcnt_r <= '0;
      pk_r <= '0; mrow_r <= '0;
      pass_r <= 1'b0; seeded_r <= 1'b0; ack_draw_r <= 1'b0;
    end else begin
      out_valid <= valid_nxt;
      case (state_r)
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == AW'(WORDS - 1)) begin
            state_r <= S_IDLE; busy <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            out_value <= '0; out_is_random <= 1'b0;
            case (in_op)
              OP_DRAW: begin
                busy <= 1'b1; state_r <= S_DRAW; ack_draw_r <= 1'b0;
              end
              OP_INIT: begin
                busy <= 1'b1; a_r <= '0; b_r <= '0; cnt_r <= '0;
                seeded_r <= in_use_seed; pass_r <= 1'b0; ack_draw_r <= 1'b0;
                for (int j = 0; j < 8; j++) v_r[j] <= GOLDEN;
                mcnt_r <= 2'd2; k_r <= '0; pk_r <= '0; mrow_r <= '0; idx_r <= '0;
                state_r <= S_PRE;
              end
              default: ;
            endcase
          end
        end
        S_DRAW: begin
          if (!ack_draw_r) begin
            ack_draw_r <= 1'b1;
          end else begin
            out_value <= rb_rd; out_is_random <= 1'b1;
            c_r <= c_r + 1'b1;
            if (c_r == AW'(WORDS - 1)) begin
              idx_r <= '0; state_r <= S_GRD;
              cnt_r <= cnt_r + 32'd1;
              b_r <= b_r + cnt_r + 32'd1;
            end else begin
              busy <= 1'b0; state_r <= S_IDLE;
            end
          end
        end
        S_PRE: begin
          case (mcnt_r)
            2'd0: begin
              k_r <= k_r + 1'b1;
              if (k_r != 3'd0) v_r[k_r - 1'b1] <= v_r[k_r - 1'b1] + seedw;
              if (k_r == 3'd7) mcnt_r <= 2'd1;
            end
            2'd1: begin
              v_r[7] <= v_r[7] + seedw; mcnt_r <= 2'd2; k_r <= '0;
            end
            2'd2: begin
              for (int j = 0; j < 8; j++) v_r[j] <= mv[j];
              mrow_r <= mrow_r + 3'd1;
              if (mrow_r == 3'd7) begin
                if (pk_r < 3'd3) begin
                  pk_r <= pk_r + 3'd1;
                end else if (pk_r == 3'd3) begin
                  pk_r <= 3'd4; mcnt_r <= seeded_r ? 2'd0 : 2'd2;
                end else begin
                  mcnt_r <= 2'd3;
                end
              end
            end
            default: begin
              k_r <= k_r + 1'b1;
              if (k_r == 3'd7) begin
                idx_r <= idx_r + AW'(8);
                if (idx_r[AW-1:3] == '1) begin
                  if (seeded_r && !pass_r) begin
                    pass_r <= 1'b1; mcnt_r <= 2'd0;
                  end else begin
                    state_r <= S_GRD;
                    cnt_r <= cnt_r + 32'd1;
                    b_r <= b_r + cnt_r + 32'd1;
                  end
                end else begin
                  mcnt_r <= seeded_r ? 2'd0 : 2'd2;
                end
              end
            end
          endcase
        end
        S_GRD: state_r <= S_GWR;
        S_GWR: begin
          x_r <= sm_rd; state_r <= S_GPA;
        end
        S_GPA: begin
          a_r <= av + sm_rd; state_r <= S_GRA;
        end
        S_GRA: begin
          y_r <= sm_rd + a_r + b_r; state_r <= S_GX;
        end
        S_GX: state_r <= S_GY;
        S_GY: begin
          b_r <= yb + x_r; state_r <= S_GB;
        end
        S_GB: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == AW'(WORDS - 1)) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_GRD;
          end
        end
        S_DONE: begin
          c_r <= '0; busy <= 1'b0; state_r <= S_IDLE;
          ack_draw_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy == (state_r != S_IDLE)) else $error("busy out of step with state");
  a_rand: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_random |-> $past(state_r) == S_DRAW) else $error("stray random word");
  a_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_random |-> out_value == 32'd0) else $error("nonzero acknowledgment");
`endif
endmodule

// ----- rtl/core/isaac_ram.sv -----
module isaac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
